>>> rtl/core/csc_pkg.sv
// Shared types and constants of the curve/straight classifier.
package csc_pkg;

  localparam int unsigned POS_W = 12;
  localparam int unsigned TOL_W = 8;
  localparam int unsigned THR_W = 4;
  localparam int unsigned HOLD_W = 8;
  localparam int unsigned CNT_OUT_W = 4;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_LEFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOTE_THR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_STEPS = 2'd3;

  localparam logic [TOL_W-1:0] TOL_RESET = 8'd3;
  localparam logic [THR_W-1:0] THR_RESET = 4'd4;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd10;
  localparam logic [HOLD_W-1:0] COUNTDOWN_RESET = 8'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_CURVE = 2'd0,
    MODE_STRAIGHT = 2'd1,
    MODE_CURVE_AP = 2'd2,
    MODE_STRAIGHT_AP = 2'd3
  } mode_t;

  typedef struct packed {
    logic follow_left;
    logic [TOL_W-1:0] curve_tolerance;
    logic [THR_W-1:0] vote_threshold;
    logic [HOLD_W-1:0] hold_steps;
  } cfg_t;

endpackage

>>> rtl/core/csc_front.sv
// Front stage: takes input words and registers the curve vote of each frame.
module csc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  csc_pkg::cfg_t                        cfg,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // right_near, right_mid, right_far, left_near, left_mid, left_far
  input  logic [csc_pkg::IN_DATA_W-1:0]        s_tdata,
  output logic                                 vote_valid,
  input  logic                                 vote_ready,
  output logic                                 vote
);

  localparam int unsigned PW = csc_pkg::POS_W;
  localparam int unsigned SW = PW + 2;

  logic signed [PW-1:0] pos_near;
  logic signed [PW-1:0] pos_mid;
  logic signed [PW-1:0] pos_far;
  logic signed [SW-1:0] delta;
  logic [SW-2:0]        mag;
  logic                 vote_now;

  always_comb begin
    if (cfg.follow_left) begin
      pos_near = s_tdata[3*PW +: PW];
      pos_mid  = s_tdata[4*PW +: PW];
      pos_far  = s_tdata[5*PW +: PW];
    end else begin
      pos_near = s_tdata[0 +: PW];
      pos_mid  = s_tdata[PW +: PW];
      pos_far  = s_tdata[2*PW +: PW];
    end
    // slope change is +-(2*mid - near - far) for either line
    delta = (SW'(pos_mid) <<< 1) - SW'(pos_near) - SW'(pos_far);
    mag = delta[SW-1] ? (SW-1)'(-delta) : delta[SW-2:0];
    vote_now = mag >= (SW-1)'(cfg.curve_tolerance);
  end

  assign s_tready = !vote_valid || vote_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_valid <= 1'b0;
    end else if (s_tready) begin
      vote_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      vote <= vote_now;
    end
  end

endmodule

>>> rtl/core/csc_queue.sv
// Short vote queue between the front and back stages.
module csc_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_vote,
  output logic out_valid,
  input  logic out_ready,
  output logic out_vote
);

  localparam int unsigned DEPTH = csc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0]  slots;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              push;
  logic              pop;

  assign in_ready  = fill != FILL_W'(DEPTH);
  assign out_valid = fill != '0;
  assign out_vote  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_vote;
    end
  end

endmodule

>>> rtl/core/csc_back.sv
// Back stage: vote window, running count, mode hold logic and output register.
module csc_back #(
  parameter int unsigned HISTORY_LEN = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  csc_pkg::cfg_t                        cfg,
  input  logic                                 vote_valid,
  output logic                                 vote_ready,
  input  logic                                 vote,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // road_mode, vote_count, zero pad
  output logic [csc_pkg::OUT_DATA_W-1:0]       m_tdata
);

  localparam int unsigned CW = $clog2(HISTORY_LEN + 1);
  localparam int unsigned XW = (CW > csc_pkg::CNT_OUT_W) ? CW : csc_pkg::CNT_OUT_W;
  localparam int unsigned HW = csc_pkg::HOLD_W;
  localparam int unsigned OW = csc_pkg::CNT_OUT_W;

  logic [HISTORY_LEN-1:0] history;
  logic [CW-1:0]          count;
  logic                   in_curve;
  logic [HW-1:0]          straight_cd;
  logic [HW-1:0]          curve_cd;

  logic [CW-1:0]          count_next;
  logic [XW-1:0]          count_x;
  logic                   in_curve_next;
  logic [HW-1:0]          straight_cd_next;
  logic [HW-1:0]          curve_cd_next;
  csc_pkg::mode_t         mode_next;
  logic [OW-1:0]          count_sat;
  logic                   take;

  assign vote_ready = !m_tvalid || m_tready;
  assign take       = vote_valid && vote_ready;

  always_comb begin
    count_next       = count + CW'(vote) - CW'(history[HISTORY_LEN-1]);
    count_x          = XW'(count_next);
    count_sat        = (count_x > XW'(15)) ? OW'(15) : count_x[OW-1:0];
    in_curve_next    = in_curve;
    straight_cd_next = straight_cd;
    curve_cd_next    = curve_cd;
    if (count_x > XW'(cfg.vote_threshold)) begin
      if (!in_curve && straight_cd != '0) begin
        straight_cd_next = straight_cd - 1'b1;
        mode_next        = csc_pkg::MODE_CURVE_AP;
      end else begin
        in_curve_next = 1'b1;
        curve_cd_next = cfg.hold_steps;
        mode_next     = csc_pkg::MODE_CURVE;
      end
    end else begin
      if (in_curve && curve_cd != '0) begin
        curve_cd_next = curve_cd - 1'b1;
        mode_next     = csc_pkg::MODE_STRAIGHT_AP;
      end else begin
        in_curve_next    = 1'b0;
        straight_cd_next = cfg.hold_steps;
        mode_next        = csc_pkg::MODE_STRAIGHT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history     <= '0;
      count       <= '0;
      in_curve    <= 1'b1;
      straight_cd <= csc_pkg::COUNTDOWN_RESET;
      curve_cd    <= csc_pkg::COUNTDOWN_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      if (vote_ready) begin
        m_tvalid <= vote_valid;
      end
      if (take) begin
        history     <= {history[HISTORY_LEN-2:0], vote};
        count       <= count_next;
        in_curve    <= in_curve_next;
        straight_cd <= straight_cd_next;
        curve_cd    <= curve_cd_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {2'b00, count_sat, mode_next};
    end
  end

endmodule

>>> rtl/core/curve_straight_classifier_core.sv
// Top level of the curve/straight classifier: config registers and stage wiring.
//
// channel   dir  tdata fields (low bit up)                                  width
// s_axis    in   right_near, right_mid, right_far, left_near, left_mid, left_far  72
// m_axis    out  road_mode[1:0], vote_count[5:2], zero[7:6]                  8
// cfg       in   cfg_we, cfg_index (0..3), cfg_wdata                         8
//
// One word per cycle is taken while nothing stalls; a frame's result is offered
// after passing the front vote register, the queue and the back output register.
// The vote window count is kept as a running sum in the back stage.
// Reset is synchronous; it clears the window and loads the curve state with
// both countdowns at ten. The two-entry queue lets the front keep taking words
// while m_tready is low, until the queue fills.
module curve_straight_classifier_core #(
  parameter int unsigned HISTORY_LEN = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // right_near, right_mid, right_far, left_near, left_mid, left_far
  input  logic [csc_pkg::IN_DATA_W-1:0]        s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // road_mode, vote_count, zero pad
  output logic [csc_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  logic                                 cfg_we,
  input  logic [csc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [csc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  csc_pkg::cfg_t cfg;
  logic          f_valid;
  logic          f_ready;
  logic          f_vote;
  logic          q_valid;
  logic          q_ready;
  logic          q_vote;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.follow_left     <= 1'b0;
      cfg.curve_tolerance <= csc_pkg::TOL_RESET;
      cfg.vote_threshold  <= csc_pkg::THR_RESET;
      cfg.hold_steps      <= csc_pkg::HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csc_pkg::REG_FOLLOW_LEFT: cfg.follow_left     <= cfg_wdata[0];
        csc_pkg::REG_CURVE_TOL:   cfg.curve_tolerance <= cfg_wdata[csc_pkg::TOL_W-1:0];
        csc_pkg::REG_VOTE_THR:    cfg.vote_threshold  <= cfg_wdata[csc_pkg::THR_W-1:0];
        csc_pkg::REG_HOLD_STEPS:  cfg.hold_steps      <= cfg_wdata[csc_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  csc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .vote_valid (f_valid),
    .vote_ready (f_ready),
    .vote       (f_vote)
  );

  csc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_vote   (f_vote),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_vote  (q_vote)
  );

  csc_back #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .vote_valid (q_valid),
    .vote_ready (q_ready),
    .vote       (q_vote),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  logic [csc_pkg::CNT_OUT_W-1:0] out_count;
  logic [csc_pkg::MODE_W-1:0]    out_mode;

  assign out_mode  = m_tdata[csc_pkg::MODE_W-1:0];
  assign out_count = m_tdata[csc_pkg::MODE_W +: csc_pkg::CNT_OUT_W];

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(out_count) <= HISTORY_LEN))
    else $error("vote count beyond window length");

  a_curve_needs_votes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_mode == csc_pkg::MODE_CURVE || out_mode == csc_pkg::MODE_CURVE_AP))
      |-> (out_count > cfg.vote_threshold || out_count == 4'd15))
    else $error("curve mode without enough votes");

  a_straight_needs_few: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_mode == csc_pkg::MODE_STRAIGHT ||
                  out_mode == csc_pkg::MODE_STRAIGHT_AP))
      |-> (out_count <= cfg.vote_threshold))
    else $error("straight mode with too many votes");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[csc_pkg::OUT_DATA_W-1:csc_pkg::MODE_W + csc_pkg::CNT_OUT_W] == '0))
    else $error("output pad bits set");

endmodule

>>> sim/tb_top.sv
// Testbench for the curve/straight classifier core: scoreboard, stream drivers and stimulus.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    csc_pkg::mode_t mode;
    logic [3:0]     votes;
  } verdict_t;

  class mode_scoreboard;
    bit         follow_left;
    logic [7:0] tol;
    logic [3:0] thr;
    logic [7:0] hold;
    bit   [9:0] votes_seen;
    bit         in_curve;
    logic [7:0] straight_cd;
    logic [7:0] curve_cd;
    verdict_t   awaited[$];
    int         errors;
    int         checked;

    function new();
      follow_left = 1'b0;
      tol         = csc_pkg::TOL_RESET;
      thr         = csc_pkg::THR_RESET;
      hold        = csc_pkg::HOLD_RESET;
      votes_seen  = '0;
      in_curve    = 1'b1;
      straight_cd = csc_pkg::COUNTDOWN_RESET;
      curve_cd    = csc_pkg::COUNTDOWN_RESET;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_reg(logic [csc_pkg::CFG_IDX_W-1:0] idx,
                          logic [csc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        csc_pkg::REG_FOLLOW_LEFT: follow_left = val[0];
        csc_pkg::REG_CURVE_TOL:   tol = val;
        csc_pkg::REG_VOTE_THR:    thr = val[3:0];
        csc_pkg::REG_HOLD_STEPS:  hold = val;
        default: ;
      endcase
    endfunction

    function void note_frame(logic [csc_pkg::IN_DATA_W-1:0] w);
      logic signed [11:0] n, m, f;
      int       d1, d2, dlt, mag, cnt;
      verdict_t v;
      if (follow_left) begin
        n = w[47:36]; m = w[59:48]; f = w[71:60];
        d1 = int'(m) - int'(n);
        d2 = int'(f) - int'(m);
      end else begin
        n = w[11:0]; m = w[23:12]; f = w[35:24];
        d1 = int'(n) - int'(m);
        d2 = int'(m) - int'(f);
      end
      dlt = d2 - d1;
      mag = (dlt < 0) ? -dlt : dlt;
      votes_seen = {votes_seen[8:0], mag >= int'(tol)};
      cnt = $countones(votes_seen);
      if (cnt > int'(thr)) begin
        if (!in_curve && straight_cd != 0) begin
          straight_cd = straight_cd - 8'd1;
          v.mode = csc_pkg::MODE_CURVE_AP;
        end else begin
          in_curve = 1'b1;
          curve_cd = hold;
          v.mode = csc_pkg::MODE_CURVE;
        end
      end else begin
        if (in_curve && curve_cd != 0) begin
          curve_cd = curve_cd - 8'd1;
          v.mode = csc_pkg::MODE_STRAIGHT_AP;
        end else begin
          in_curve = 1'b0;
          straight_cd = hold;
          v.mode = csc_pkg::MODE_STRAIGHT;
        end
      end
      v.votes = (cnt > 15) ? 4'd15 : 4'(cnt);
      awaited.push_back(v);
    endfunction

    function void check_word(logic [csc_pkg::OUT_DATA_W-1:0] w);
      verdict_t v;
      if (awaited.size() == 0) begin
        $error("unexpected result word %h", w);
        errors++;
      end else begin
        v = awaited.pop_front();
        checked++;
        if (w[1:0] !== v.mode) begin
          $error("road_mode expected %0d got %0d", v.mode, w[1:0]);
          errors++;
        end
        if (w[5:2] !== v.votes) begin
          $error("vote_count expected %0d got %0d", v.votes, w[5:2]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [csc_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [csc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we;
  logic [csc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [csc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mode_scoreboard sb = new();
  bit  calm = 1'b0;
  int  hold_reqs = 0;
  int  frames = 0;
  int  settings = 0;
  int  cycles = 0;

  curve_straight_classifier_core dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 500000) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    int served;
    int r;
    stall_left = 0;
    served = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
      if (hold_reqs != served) begin
        served++;
        stall_left = 80;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [csc_pkg::IN_DATA_W-1:0] pack6(int rn, int rm, int rf,
                                                          int ln, int lm, int lf);
    return {12'(lf), 12'(lm), 12'(ln), 12'(rf), 12'(rm), 12'(rn)};
  endfunction

  function automatic logic [csc_pkg::IN_DATA_W-1:0] make_frame(bit curvy);
    logic [95:0] noise;
    logic [35:0] other;
    logic [35:0] line;
    int n, s, t, mag, dd;
    noise = {$urandom(), $urandom(), $urandom()};
    if ($urandom_range(0, 99) < 12) return noise[csc_pkg::IN_DATA_W-1:0];
    other = noise[35:0];
    n = int'($urandom_range(0, 4095)) - 2048;
    s = int'($urandom_range(0, 600)) - 300;
    t = int'(sb.tol);
    if (curvy) mag = t + int'($urandom_range(0, 250));
    else if ($urandom_range(0, 4) == 0) mag = (t > 0) ? t - int'($urandom_range(0, 1)) : 0;
    else mag = (t > 0) ? int'($urandom_range(0, t - 1)) : 0;
    dd = $urandom_range(0, 1) ? mag : -mag;
    if (sb.follow_left) begin
      line = {12'(n + 2 * s + dd), 12'(n + s), 12'(n)};
      return {line, other};
    end
    line = {12'(n - 2 * s - dd), 12'(n - s), 12'(n)};
    return {other, line};
  endfunction

  task automatic send_frame(logic [csc_pkg::IN_DATA_W-1:0] w);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    sb.note_frame(w);
    frames++;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [csc_pkg::CFG_IDX_W-1:0] idx,
                           logic [csc_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(bit fl, int tol, int thr, int hold);
    drain();
    write_reg(csc_pkg::REG_FOLLOW_LEFT, {7'd0, fl});
    write_reg(csc_pkg::REG_CURVE_TOL, 8'(tol));
    write_reg(csc_pkg::REG_VOTE_THR, 8'(thr));
    write_reg(csc_pkg::REG_HOLD_STEPS, 8'(hold));
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(int n_items);
    int  sent;
    int  seg_len;
    bit  curvy;
    sent = 0;
    while (sent < n_items) begin
      curvy = $urandom_range(0, 1);
      if ($urandom_range(0, 9) == 0) seg_len = $urandom_range(1, int'(sb.hold) + 14);
      else seg_len = $urandom_range(1, 12);
      for (int i = 0; i < seg_len && sent < n_items; i++) begin
        send_frame(make_frame(curvy));
        sent++;
      end
    end
  endtask

  initial begin
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst       <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: extremes, tolerance edge, then curve and straight runs
    send_frame(pack6(0, 0, 0, 0, 0, 0));
    send_frame(pack6(2047, -2048, 2047, -2048, 2047, -2048));
    send_frame(pack6(-2048, 2047, -2048, 2047, -2048, 2047));
    send_frame(pack6(2047, 2047, 2047, 2047, 2047, 2047));
    send_frame(pack6(-2048, -2048, -2048, -2048, -2048, -2048));
    send_frame(pack6(0, 0, -3, 1365, -1366, 1365));
    send_frame(pack6(0, 0, -2, -1366, 1365, -1366));
    send_frame(pack6(0, 0, 3, 0, 0, 0));
    repeat (8) send_frame(pack6(0, 100, 0, 0, 0, 0));
    repeat (8) send_frame(pack6(5, 5, 5, 0, 700, 0));

    program_regs(1'b1, 3, 4, 10);
    hold_reqs++;
    run_phase(100);
    program_regs(1'b0, 0, 4, 5);
    run_phase(60);
    program_regs(1'b1, 255, 0, 0);
    run_phase(80);
    program_regs(1'b0, 20, 10, 3);
    run_phase(60);
    program_regs(1'b1, 8, 5, 255);
    hold_reqs++;
    run_phase(300);
    calm = 1'b1;
    program_regs(1'b0, 1, 2, 0);
    run_phase(100);
    for (int p = 0; p < 6; p++) begin
      calm = (p == 3);
      program_regs($urandom_range(0, 1), $urandom_range(0, 40), $urandom_range(0, 10),
                   $urandom_range(0, 20));
      if (p == 1) hold_reqs++;
      run_phase(120);
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    $display("run covered %0d frames over %0d register settings, %0d results compared",
             frames, settings + 1, sb.checked);
    $display("long receiver hold-offs: %0d, mismatches: %0d", hold_reqs, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
